// ===== rtl/w2s_pkg.sv =====
// Shared constants and register codes for the world-to-screen projection block.
package w2s_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int COEF_BITS_DEF  = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int IN_W   = 24;
	localparam int PIX_W  = 16;
	localparam int SIZE_W = 13;
	localparam int CFG_W  = 64;
	localparam int LANE_W = 16;
	localparam int IDX_W  = 3;

	// Quotient bits kept by the divider; anything larger saturates the pixel anyway.
	localparam int QUO_BITS = PIX_W + 1;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1920;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;

	typedef enum logic [IDX_W-1:0] {
		REG_ROW_X  = 3'd0,
		REG_ROW_Y  = 3'd1,
		REG_ROW_W  = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} cfg_reg_t;

endpackage

// ===== rtl/world_to_screen_projection.sv =====
// Top level of the world-to-screen perspective projection pipeline.
// The block takes one world point per cycle unless stalled, returns one result per point,
// in order, after QUO_BITS + 6 register stages. Stage one forms the nine coefficient
// products, stage two the clip sums, stages three and four scale clip x and y by the half
// viewport size in two partial products, stage five takes magnitudes and detects quotients
// that would saturate, then a restoring divider resolves one quotient bit per stage, and
// the last stage applies floor rounding, the viewport offset and 16-bit saturation. The
// divider's one-bit-per-stage depth sets the latency.
// Stalls propagate stage by stage, so empty stages keep filling while the output waits.
module world_to_screen_projection #(
	parameter int COORD_BITS = w2s_pkg::COORD_BITS_DEF,
	parameter int COEF_BITS  = w2s_pkg::COEF_BITS_DEF,
	parameter int FRAC_BITS  = w2s_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [w2s_pkg::IDX_W-1:0]         cfg_index,
	input  logic [w2s_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [w2s_pkg::IN_W-1:0]   world_x,
	input  logic signed [w2s_pkg::IN_W-1:0]   world_y,
	input  logic signed [w2s_pkg::IN_W-1:0]   world_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              visible,
	output logic signed [w2s_pkg::PIX_W-1:0]  pixel_x,
	output logic signed [w2s_pkg::PIX_W-1:0]  pixel_y
);
	import w2s_pkg::*;

	localparam int PW   = COORD_BITS + COEF_BITS;
	localparam int CW   = PW + 2;
	localparam int NW   = CW + SIZE_W;
	localparam int LO_W = CW / 2;
	localparam int HI_W = CW - LO_W;
	localparam int QB   = QUO_BITS;
	localparam int DE   = 5 + QB;
	localparam int NST  = DE + 1;
	localparam int OVW  = CW + QB + 1;
	localparam int RSW  = QB + 3;
	localparam longint NEAR_Q = ((longint'(1) << (2 * FRAC_BITS)) + 5) / 10;
	localparam logic signed [CW-1:0] NEAR_C = CW'(NEAR_Q);
	localparam logic signed [RSW-1:0] PIX_HI = RSW'((longint'(1) << (PIX_W - 1)) - 1);
	localparam logic signed [RSW-1:0] PIX_LO = -RSW'(longint'(1) << (PIX_W - 1));

	typedef struct packed {
		logic                 vis;
		logic [CW-1:0]        dvs;
		logic [1:0]           neg;
		logic [1:0]           ovf;
		logic [1:0][NW-1:0]   rem;
		logic [1:0][QB-1:0]   quo;
	} div_t;

	// Configuration registers.
	logic [CFG_W-1:0]  rows_q [3];
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic signed [SIZE_W-1:0] half_w;
	logic signed [SIZE_W-1:0] half_h;

	assign cfg_ready = 1'b1;
	assign half_w = $signed({1'b0, width_q[SIZE_W-1:1]});
	assign half_h = $signed({1'b0, height_q[SIZE_W-1:1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= '0;
			rows_q[1] <= '0;
			rows_q[2] <= '0;
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_X:  rows_q[0] <= cfg_data;
				REG_ROW_Y:  rows_q[1] <= cfg_data;
				REG_ROW_W:  rows_q[2] <= cfg_data;
				REG_WIDTH:  width_q   <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q  <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valids and per-stage load enables.
	logic vld_q [1:NST];
	logic en    [1:NST+1];

	always_comb begin
		en[NST+1] = out_ready;
		for (int k = NST; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: coefficient products.
	logic signed [COEF_BITS-1:0]  coef [3][4];
	logic signed [COORD_BITS-1:0] pt   [3];
	logic signed [PW-1:0] prod_s1  [3][3];
	logic signed [CW-1:0] trans_s1 [3];

	always_comb begin
		pt[0] = $signed(world_x[COORD_BITS-1:0]);
		pt[1] = $signed(world_y[COORD_BITS-1:0]);
		pt[2] = $signed(world_z[COORD_BITS-1:0]);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				coef[r][c] = $signed(rows_q[r][c*LANE_W +: COEF_BITS]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= PW'(pt[c]) * PW'(coef[r][c]);
				end
				trans_s1[r] <= CW'(coef[r][3]) <<< FRAC_BITS;
			end
		end
	end

	// Stage 2: clip sums.
	logic signed [CW-1:0] clip_s2 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int r = 0; r < 3; r++) begin
				clip_s2[r] <= CW'(prod_s1[r][0]) + CW'(prod_s1[r][1])
					+ CW'(prod_s1[r][2]) + trans_s1[r];
			end
		end
	end

	// Stage 3: half size times clip x and y, split into low and high partial products.
	logic signed [SIZE_W+LO_W:0]    plo_s3 [2];
	logic signed [SIZE_W+HI_W-1:0]  phi_s3 [2];
	logic [CW-1:0]                  dvs_s3;
	logic                           vis_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			plo_s3[0] <= (SIZE_W+LO_W+1)'(half_w)
				* $signed({1'b0, clip_s2[0][LO_W-1:0]});
			plo_s3[1] <= (SIZE_W+LO_W+1)'(half_h)
				* $signed({1'b0, clip_s2[1][LO_W-1:0]});
			phi_s3[0] <= (SIZE_W+HI_W)'(half_w)
				* (SIZE_W+HI_W)'($signed(clip_s2[0][CW-1:LO_W]));
			phi_s3[1] <= (SIZE_W+HI_W)'(half_h)
				* (SIZE_W+HI_W)'($signed(clip_s2[1][CW-1:LO_W]));
			dvs_s3    <= clip_s2[2];
			vis_s3    <= (clip_s2[2] >= NEAR_C);
		end
	end

	// Stage 4: combine the partial products into the full numerators.
	logic signed [NW-1:0] num_s4 [2];
	logic [CW-1:0]        dvs_s4;
	logic                 vis_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int r = 0; r < 2; r++) begin
				num_s4[r] <= (NW'(phi_s3[r]) <<< LO_W) + NW'(plo_s3[r]);
			end
			dvs_s4 <= dvs_s3;
			vis_s4 <= vis_s3;
		end
	end

	// Stage 5: magnitudes and early detection of quotients that cannot fit.
	div_t div_s [5:DE];
	div_t div_init;

	always_comb begin
		div_init     = '0;
		div_init.vis = vis_s4;
		div_init.dvs = dvs_s4;
		for (int r = 0; r < 2; r++) begin
			div_init.neg[r] = num_s4[r][NW-1];
			div_init.rem[r] = num_s4[r][NW-1] ? NW'(-num_s4[r]) : NW'(num_s4[r]);
			div_init.ovf[r] = OVW'(div_init.rem[r]) >= (OVW'(dvs_s4) << QB);
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			div_s[5] <= div_init;
		end
	end

	// Divider stages: one quotient bit per stage, most significant first.
	for (genvar k = 6; k <= DE; k++) begin : g_div
		div_t nxt;
		logic [1:0][NW-1:0] rem_nxt;
		logic [1:0]         qbit;

		for (genvar r = 0; r < 2; r++) begin : g_lane
			w2s_div_step #(
				.RW(NW),
				.DW(CW),
				.SH(DE - k)
			) u_step (
				.rem     (div_s[k-1].rem[r]),
				.dvs     (div_s[k-1].dvs),
				.rem_nxt (rem_nxt[r]),
				.quo_bit (qbit[r])
			);
		end

		always_comb begin
			nxt = div_s[k-1];
			for (int r = 0; r < 2; r++) begin
				nxt.rem[r]          = rem_nxt[r];
				nxt.quo[r][DE - k]  = qbit[r];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				div_s[k] <= nxt;
			end
		end
	end

	// Last stage: floor rounding, viewport offset and saturation.
	function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [RSW-1:0] v);
		logic signed [PIX_W-1:0] res;
		if (v > PIX_HI) begin
			res = PIX_HI[PIX_W-1:0];
		end else if (v < PIX_LO) begin
			res = PIX_LO[PIX_W-1:0];
		end else begin
			res = v[PIX_W-1:0];
		end
		return res;
	endfunction

	logic [QB-1:0]           q_fin [2];
	logic signed [RSW-1:0]   q_flr [2];
	logic signed [RSW-1:0]   sum_x;
	logic signed [RSW-1:0]   sum_y;
	logic                    vis_sn;
	logic signed [PIX_W-1:0] px_sn;
	logic signed [PIX_W-1:0] py_sn;

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			q_fin[r] = div_s[DE].ovf[r] ? '1 : div_s[DE].quo[r];
			if (div_s[DE].neg[r]) begin
				q_flr[r] = -$signed(RSW'(q_fin[r]))
					- RSW'(div_s[DE].rem[r] != '0);
			end else begin
				q_flr[r] = $signed(RSW'(q_fin[r]));
			end
		end
		sum_x = RSW'(half_w) + q_flr[0];
		sum_y = RSW'(half_h) - q_flr[1];
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			vis_sn <= div_s[DE].vis;
			px_sn  <= div_s[DE].vis ? sat_pix(sum_x) : '0;
			py_sn  <= div_s[DE].vis ? sat_pix(sum_y) : '0;
		end
	end

	assign visible = vis_sn;
	assign pixel_x = px_sn;
	assign pixel_y = py_sn;

`ifndef SYNTH
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> pixel_x == '0 && pixel_y == '0)
		else $error("hidden point carries a nonzero pixel");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while the output side is free");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[1])
		else $error("accepted point did not enter the first stage");
`endif

endmodule

// ===== rtl/w2s_div_step.sv =====
// One restoring division step: compares the remainder with the shifted divisor.
module w2s_div_step #(
	parameter int RW = 55,
	parameter int DW = 42,
	parameter int SH = 0
) (
	input  logic [RW-1:0] rem,
	input  logic [DW-1:0] dvs,
	output logic [RW-1:0] rem_nxt,
	output logic          quo_bit
);
	localparam int XW = ((RW > DW + SH) ? RW : DW + SH) + 1;

	logic [XW-1:0] r_x;
	logic [XW-1:0] d_x;
	logic [XW-1:0] diff;

	assign r_x     = XW'(rem);
	assign d_x     = XW'(dvs) << SH;
	assign diff    = r_x - d_x;
	assign quo_bit = (r_x >= d_x);
	assign rem_nxt = quo_bit ? diff[RW-1:0] : rem;

endmodule
